@@ hdl/hrhp_pkg.sv @@
// ----------------------------------------------------------------------------
// hrhp_pkg
// Types and constants shared by the HTTP request header parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

    // Result kinds
    localparam logic [1:0] KIND_PATH = 2'd0;
    localparam logic [1:0] KIND_HOST = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // End statuses
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MALFORM  = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    // Register indexes
    localparam logic REG_MAX_LINE_LEN     = 1'b0;
    localparam logic REG_MAX_HEADER_LINES = 1'b1;

    localparam logic [15:0] MAX_LINE_LEN_RST     = 16'd8192;
    localparam logic [7:0]  MAX_HEADER_LINES_RST = 8'd100;

    typedef struct packed {
        logic       action;
        logic [7:0] data;
    } req_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_out;
        logic       field_first;
        logic [1:0] status;
        logic       keep_alive;
        logic       last;
    } res_item_t;

endpackage

@@ hdl/http_request_header_parser.sv @@
// ----------------------------------------------------------------------------
// http_request_header_parser
// Byte-serial HTTP/1.x GET request header parser with path and host streaming.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  request  | req_valid/req_stall | req : action, data (one byte)
//  result   | res_valid/res_stall | res : kind, data_out, field_first,
//           |                     |       status, keep_alive, last
//  config   | APB write/read      | max_line_len (0x0), max_header_lines (0x4)
//
//  One byte is parsed per cycle unless stalled; the whole per-byte update is
//  one pass of logic from the accepted byte into a four-entry result queue.
//  A byte can yield two results (a held CR turning into content plus the
//  byte), so a byte is taken while the queue holds two or fewer entries.
//  Reset clears the parser state, the queue and the registers to defaults.
//  A stalled result holds its queue slot until taken.
//
module http_request_header_parser
    import hrhp_pkg::*;
#(
    parameter int LINE_LEN_MAX     = 65535,
    parameter int HEADER_LIMIT_MAX = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_item_t   req,
    output logic        res_valid,
    input  logic        res_stall,
    output res_item_t   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LW = $clog2(LINE_LEN_MAX + 1);
    localparam int HW = $clog2(HEADER_LIMIT_MAX + 1);

    localparam logic [1:0] PH_REQ  = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_HALT = 2'd2;

    // line flag bits
    localparam int F_BAD     = 0;
    localparam int F_OVER    = 1;
    localparam int R_SEG_LO  = 2;
    localparam int R_V10     = 4;
    localparam int H_COLON   = 2;
    localparam int H_NOTHOST = 3;
    localparam int H_NOTCONN = 4;
    localparam int H_NOTCLEN = 5;
    localparam int H_STARTED = 6;
    localparam int H_CLBAD   = 7;
    localparam int H_CLNZ    = 8;
    localparam int H_CLOSE   = 9;
    localparam int H_KA      = 10;

    typedef struct packed {
        logic [1:0]    phase;
        logic [4:0]    token_pos;
        logic [LW-1:0] line_length;
        logic [HW-1:0] header_count;
        logic          cr_pending;
        logic [11:0]   flags;
        logic [2:0]    close_match;
        logic [3:0]    ka_match;
        logic          keep_alive_flag;
        logic          length_nonzero;
    } pst_t;

    typedef struct packed {
        logic [1:0] n;
        res_item_t  r0;
        res_item_t  r1;
    } emit_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] max_line_len_reg;
    logic [7:0]  max_header_lines_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_line_len_reg     <= MAX_LINE_LEN_RST;
            max_header_lines_reg <= MAX_HEADER_LINES_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_MAX_LINE_LEN)
                max_line_len_reg <= pwdata[15:0];
            else
                max_header_lines_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_MAX_LINE_LEN)
            prdata = {16'd0, max_line_len_reg};
        else
            prdata = {24'd0, max_header_lines_reg};
    end

    // Effective limits, clamped to the build-time maxima
    logic [LW-1:0] line_lim;
    logic [HW:0]   hdr_lim;

    assign line_lim = (max_line_len_reg > 16'(LINE_LEN_MAX)) ? LW'(LINE_LEN_MAX)
                                                              : max_line_len_reg[LW-1:0];
    assign hdr_lim  = (max_header_lines_reg > 8'(HEADER_LIMIT_MAX))
                    ? (HW+1)'(HEADER_LIMIT_MAX) : (HW+1)'(max_header_lines_reg);

    // ------------------------------------------------------------------
    // Keyword tables
    // ------------------------------------------------------------------
    function automatic logic [7:0] kw_get(input logic [4:0] p);
        case (p)
            5'd0:    kw_get = "G";
            5'd1:    kw_get = "E";
            default: kw_get = "T";
        endcase
    endfunction

    function automatic logic [7:0] kw_ver(input logic [4:0] p);
        case (p)
            5'd0:    kw_ver = "H";
            5'd1:    kw_ver = "T";
            5'd2:    kw_ver = "T";
            5'd3:    kw_ver = "P";
            5'd4:    kw_ver = "/";
            5'd5:    kw_ver = "1";
            default: kw_ver = ".";
        endcase
    endfunction

    function automatic logic [7:0] kw_host(input logic [4:0] p);
        case (p)
            5'd0:    kw_host = "h";
            5'd1:    kw_host = "o";
            5'd2:    kw_host = "s";
            default: kw_host = "t";
        endcase
    endfunction

    function automatic logic [7:0] kw_conn(input logic [4:0] p);
        case (p)
            5'd0:    kw_conn = "c";
            5'd1:    kw_conn = "o";
            5'd2:    kw_conn = "n";
            5'd3:    kw_conn = "n";
            5'd4:    kw_conn = "e";
            5'd5:    kw_conn = "c";
            5'd6:    kw_conn = "t";
            5'd7:    kw_conn = "i";
            5'd8:    kw_conn = "o";
            default: kw_conn = "n";
        endcase
    endfunction

    function automatic logic [7:0] kw_clen(input logic [4:0] p);
        case (p)
            5'd0:    kw_clen = "c";
            5'd1:    kw_clen = "o";
            5'd2:    kw_clen = "n";
            5'd3:    kw_clen = "t";
            5'd4:    kw_clen = "e";
            5'd5:    kw_clen = "n";
            5'd6:    kw_clen = "t";
            5'd7:    kw_clen = "-";
            5'd8:    kw_clen = "l";
            5'd9:    kw_clen = "e";
            5'd10:   kw_clen = "n";
            5'd11:   kw_clen = "g";
            5'd12:   kw_clen = "t";
            default: kw_clen = "h";
        endcase
    endfunction

    function automatic logic [7:0] kw_close(input logic [2:0] p);
        case (p)
            3'd0:    kw_close = "c";
            3'd1:    kw_close = "l";
            3'd2:    kw_close = "o";
            3'd3:    kw_close = "s";
            default: kw_close = "e";
        endcase
    endfunction

    function automatic logic [7:0] kw_ka(input logic [3:0] p);
        case (p)
            4'd0:    kw_ka = "k";
            4'd1:    kw_ka = "e";
            4'd2:    kw_ka = "e";
            4'd3:    kw_ka = "p";
            4'd4:    kw_ka = "-";
            4'd5:    kw_ka = "a";
            4'd6:    kw_ka = "l";
            4'd7:    kw_ka = "i";
            4'd8:    kw_ka = "v";
            default: kw_ka = "e";
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Per-byte update
    // ------------------------------------------------------------------
    function automatic emit_t push(input emit_t e, input logic [1:0] kind,
                                   input logic [7:0] d, input logic first,
                                   input logic [1:0] st, input logic ka);
        res_item_t r;
        emit_t     o;
        r.kind        = kind;
        r.data_out    = d;
        r.field_first = first;
        r.status      = st;
        r.keep_alive  = ka;
        r.last        = 1'b0;
        o = e;
        if (e.n == 2'd0)
        begin
            o.r0 = r;
            o.n  = 2'd1;
        end
        else if (e.n == 2'd1)
        begin
            o.r1 = r;
            o.n  = 2'd2;
        end
        return o;
    endfunction

    function automatic void req_char(inout pst_t s, inout emit_t e, input logic [7:0] c);
        logic [1:0] seg;
        logic [4:0] p;
        seg = s.flags[R_SEG_LO +: 2];
        p   = s.token_pos;
        if (c == " ")
        begin
            if (seg == 2'd0)
            begin
                if (p != 5'd3)
                    s.flags[F_BAD] = 1'b1;
            end
            else if (seg == 2'd1)
            begin
                if (p == 5'd0)
                    s.flags[F_BAD] = 1'b1;
            end
            else
            begin
                s.flags[F_BAD] = 1'b1;
                return;
            end
            s.flags[R_SEG_LO +: 2] = seg + 2'd1;
            s.token_pos = 5'd0;
            return;
        end
        if (seg == 2'd0)
        begin
            if (p >= 5'd3 || c != kw_get(p))
                s.flags[F_BAD] = 1'b1;
        end
        else if (seg == 2'd1)
        begin
            if (p == 5'd0 && c != "/")
                s.flags[F_BAD] = 1'b1;
            if (!s.flags[F_BAD] && !s.flags[F_OVER])
                e = push(e, KIND_PATH, c, p == 5'd0, ST_OK, 1'b0);
        end
        else
        begin
            if (p < 5'd7)
            begin
                if (c != kw_ver(p))
                    s.flags[F_BAD] = 1'b1;
            end
            else if (p == 5'd7)
            begin
                if (c == "0")
                    s.flags[R_V10] = 1'b1;
                else if (c != "1")
                    s.flags[F_BAD] = 1'b1;
            end
            else
            begin
                s.flags[F_BAD] = 1'b1;
            end
        end
        if (s.token_pos < 5'd31)
            s.token_pos = s.token_pos + 5'd1;
    endfunction

    function automatic void hdr_char(inout pst_t s, inout emit_t e, input logic [7:0] c);
        logic [7:0] lc;
        logic [4:0] p;
        logic       first;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        p  = s.token_pos;
        if (!s.flags[H_COLON])
        begin
            if (c == ":")
            begin
                s.flags[H_COLON] = 1'b1;
                if (p != 5'd4)
                    s.flags[H_NOTHOST] = 1'b1;
                if (p != 5'd10)
                    s.flags[H_NOTCONN] = 1'b1;
                if (p != 5'd14)
                    s.flags[H_NOTCLEN] = 1'b1;
                return;
            end
            if (p >= 5'd4 || lc != kw_host(p))
                s.flags[H_NOTHOST] = 1'b1;
            if (p >= 5'd10 || lc != kw_conn(p))
                s.flags[H_NOTCONN] = 1'b1;
            if (p >= 5'd14 || lc != kw_clen(p))
                s.flags[H_NOTCLEN] = 1'b1;
            if (s.token_pos < 5'd31)
                s.token_pos = s.token_pos + 5'd1;
            return;
        end
        if (!s.flags[H_NOTCONN])
        begin
            // substring search for "close"
            if (s.close_match < 3'd5 && lc == kw_close(s.close_match))
                s.close_match = s.close_match + 3'd1;
            else
                s.close_match = (lc == kw_close(3'd0)) ? 3'd1 : 3'd0;
            if (s.close_match >= 3'd5)
            begin
                s.flags[H_CLOSE] = 1'b1;
                s.close_match    = 3'd0;
            end
            // substring search for "keep-alive"
            if (s.ka_match < 4'd10 && lc == kw_ka(s.ka_match))
                s.ka_match = s.ka_match + 4'd1;
            else
                s.ka_match = (lc == kw_ka(4'd0)) ? 4'd1 : 4'd0;
            if (s.ka_match >= 4'd10)
            begin
                s.flags[H_KA] = 1'b1;
                s.ka_match    = 4'd0;
            end
        end
        if (!s.flags[H_STARTED] && c == " ")
            return;
        first = !s.flags[H_STARTED];
        s.flags[H_STARTED] = 1'b1;
        if (!s.flags[H_NOTHOST] && !s.flags[F_OVER])
            e = push(e, KIND_HOST, c, first, ST_OK, 1'b0);
        if (!s.flags[H_NOTCLEN])
        begin
            if (c < "0" || c > "9")
                s.flags[H_CLBAD] = 1'b1;
            else if (c != "0")
                s.flags[H_CLNZ] = 1'b1;
        end
    endfunction

    function automatic void content_byte(inout pst_t s, inout emit_t e,
                                         input logic [7:0] c, input logic [LW-1:0] lim);
        if (s.line_length >= lim)
            s.flags[F_OVER] = 1'b1;
        if (s.line_length < LW'(LINE_LEN_MAX))
            s.line_length = s.line_length + LW'(1);
        if (s.phase == PH_REQ)
            req_char(s, e, c);
        else
            hdr_char(s, e, c);
    endfunction

    function automatic void finish(inout pst_t s, inout emit_t e, input logic [1:0] st);
        e = push(e, KIND_END, 8'd0, 1'b0, st, (st == ST_OK) ? s.keep_alive_flag : 1'b0);
        if (st != ST_OK)
            s.phase = PH_HALT;
        else
        begin
            s.phase           = PH_REQ;
            s.keep_alive_flag = 1'b1;
            s.length_nonzero  = 1'b0;
            s.header_count    = '0;
        end
    endfunction

    function automatic void line_end(inout pst_t s, inout emit_t e, input logic [HW:0] hlim);
        if (s.flags[F_OVER])
            finish(s, e, ST_TOO_LONG);
        else if (s.phase == PH_REQ)
        begin
            if (!s.flags[F_BAD] && s.flags[R_SEG_LO +: 2] == 2'd2 && s.token_pos == 5'd8)
            begin
                s.phase          = PH_HDR;
                s.header_count   = '0;
                s.length_nonzero = 1'b0;
                if (s.flags[R_V10])
                    s.keep_alive_flag = 1'b0;
            end
            else
                finish(s, e, ST_MALFORM);
        end
        else if (s.line_length == '0)
            finish(s, e, s.length_nonzero ? ST_MALFORM : ST_OK);
        else if ({1'b0, s.header_count} + (HW+1)'(1) > hlim)
            finish(s, e, ST_TOO_LONG);
        else
        begin
            s.header_count = s.header_count + HW'(1);
            if (!s.flags[H_COLON])
                finish(s, e, ST_MALFORM);
            else if (!s.flags[H_NOTCLEN])
            begin
                if (!s.flags[H_STARTED] || s.flags[H_CLBAD])
                    finish(s, e, ST_MALFORM);
                else
                    s.length_nonzero = s.flags[H_CLNZ];
            end
            else if (!s.flags[H_NOTCONN])
            begin
                if (s.flags[H_CLOSE])
                    s.keep_alive_flag = 1'b0;
                else if (s.flags[H_KA])
                    s.keep_alive_flag = 1'b1;
            end
        end
        s.token_pos   = '0;
        s.line_length = '0;
        s.flags       = '0;
        s.close_match = '0;
        s.ka_match    = '0;
    endfunction

    // ------------------------------------------------------------------
    // Parser state and next-state logic
    // ------------------------------------------------------------------
    pst_t  pst_reg, pst_next;
    emit_t emit;
    logic  req_take;

    assign req_take = req_valid && !req_stall;

    always_comb
    begin
        pst_t  s;
        emit_t e;
        s = pst_reg;
        e = '0;
        if (req.action)
        begin
            // clear the request, keep the registers
            s                 = '0;
            s.phase           = PH_REQ;
            s.keep_alive_flag = 1'b1;
        end
        else if (s.phase == PH_REQ || s.phase == PH_HDR)
        begin
            if (s.cr_pending)
            begin
                if (req.data == 8'h0a)
                begin
                    s.cr_pending = 1'b0;
                    line_end(s, e, hdr_lim);
                end
                else
                begin
                    // held CR was line content after all
                    content_byte(s, e, 8'h0d, line_lim);
                    if (req.data == 8'h0d)
                        s.cr_pending = 1'b1;
                    else
                    begin
                        s.cr_pending = 1'b0;
                        content_byte(s, e, req.data, line_lim);
                    end
                end
            end
            else if (req.data == 8'h0d)
                s.cr_pending = 1'b1;
            else
                content_byte(s, e, req.data, line_lim);
        end
        // mark the final result of this byte
        if (e.n == 2'd1)
            e.r0.last = 1'b1;
        else if (e.n == 2'd2)
            e.r1.last = 1'b1;
        pst_next = s;
        emit     = e;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pst_reg                 <= '0;
            pst_reg.phase           <= PH_REQ;
            pst_reg.keep_alive_flag <= 1'b1;
        end
        else if (req_take)
            pst_reg <= pst_next;
    end

    // ------------------------------------------------------------------
    // Result queue: four entries, up to two written per byte
    // ------------------------------------------------------------------
    res_item_t  q_mem [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic       res_take;
    logic [1:0] n_wr;

    assign req_stall = (count_reg > 3'd2);
    assign res_valid = (count_reg != 3'd0);
    assign res       = q_mem[rd_ptr_reg];
    assign res_take  = res_valid && !res_stall;
    assign n_wr      = req_take ? emit.n : 2'd0;

    always_ff @(posedge clk)
    begin
        if (n_wr != 2'd0)
            q_mem[wr_ptr_reg] <= emit.r0;
        if (n_wr == 2'd2)
            q_mem[wr_ptr_reg + 2'd1] <= emit.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + n_wr;
            if (res_take)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + {1'b0, n_wr} - {2'b00, res_take};
        end
    end

endmodule
